/* rtl/eef_pkg.sv */
// shared types, constants and latencies of the extended exponent float alu
`default_nettype none
package eef_pkg;

  localparam int FRAC_W = 52;
  localparam int SIG_W  = FRAC_W + 1;
  localparam int EXP_W  = 64;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_MUL = 2'd1;
  localparam logic [1:0] FUNC_DIV = 2'd2;

  // pipeline depths of the three units
  localparam int ADD_LAT         = 3;
  localparam int MUL_LAT         = 5;
  localparam int DIV_STEPS       = 2;
  localparam int DIV_ITER_STAGES = FRAC_W / DIV_STEPS;
  localparam int DIV_LAT         = DIV_ITER_STAGES + 3;

  typedef struct packed {
    logic              zero;
    logic [EXP_W-1:0]  exp;
    logic [FRAC_W-1:0] frac;
  } op_t;

  typedef struct packed {
    logic              zero;
    logic [EXP_W-1:0]  exp;
    logic [FRAC_W-1:0] frac;
    logic              err;
  } res_t;

endpackage
`default_nettype wire

/* rtl/extended_exponent_float_alu.sv */
// top level of the extended exponent float alu: units, latency alignment, result select
`default_nettype none
// Accepts one word per clock whenever start is high (busy is always low) and
// delivers its result on the res ports, marked by done for one cycle; results
// come out in order, one per accepted word, and cannot be held off. The depth
// of the pipeline is set by the divider: one setup stage, 26 stages of
// two restoring quotient steps each, a rounding compare stage and an increment
// stage, plus the output register. Adder and multiplier results are delayed to
// the same depth so all three operations share one result slot per word.
module extended_exponent_float_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic        a_zero,
  input  wire logic [63:0] a_exp,
  input  wire logic [51:0] a_frac,
  input  wire logic        b_zero,
  input  wire logic [63:0] b_exp,
  input  wire logic [51:0] b_frac,
  output logic             done,
  output logic             res_zero,
  output logic [63:0]      res_exp,
  output logic [51:0]      res_frac,
  output logic             div_error
);

  localparam int LAT     = eef_pkg::DIV_LAT;
  localparam int ADD_PAD = LAT - eef_pkg::ADD_LAT;
  localparam int MUL_PAD = LAT - eef_pkg::MUL_LAT;

  eef_pkg::op_t  a_op, b_op;
  eef_pkg::res_t add_res, mul_res, div_res;

  // delay lines that line adder and multiplier up with the divider
  eef_pkg::res_t add_dly [0:ADD_PAD-1];
  eef_pkg::res_t mul_dly [0:MUL_PAD-1];

  // valid bits and operation select travel with each word
  logic [LAT-1:0] vld;
  logic [1:0]     func_dly [0:LAT-1];

  eef_pkg::res_t sel;

  // no back pressure anywhere in the pipeline
  assign busy = 1'b0;

  assign a_op = '{zero: a_zero, exp: a_exp, frac: a_frac};
  assign b_op = '{zero: b_zero, exp: b_exp, frac: b_frac};

  eef_add u_add (.clk(clk), .a(a_op), .b(b_op), .res(add_res));
  eef_mul u_mul (.clk(clk), .a(a_op), .b(b_op), .res(mul_res));
  eef_div u_div (.clk(clk), .a(a_op), .b(b_op), .res(div_res));

  always_ff @(posedge clk) begin
    add_dly[0] <= add_res;
    for (int k = 1; k < ADD_PAD; k++) begin
      add_dly[k] <= add_dly[k-1];
    end
    mul_dly[0] <= mul_res;
    for (int k = 1; k < MUL_PAD; k++) begin
      mul_dly[k] <= mul_dly[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    func_dly[0] <= func;
    for (int k = 1; k < LAT; k++) begin
      func_dly[k] <= func_dly[k-1];
    end
  end

  // unused selector gives a plain zero result
  always_comb begin
    case (func_dly[LAT-1])
      eef_pkg::FUNC_ADD: sel = add_dly[ADD_PAD-1];
      eef_pkg::FUNC_MUL: sel = mul_dly[MUL_PAD-1];
      eef_pkg::FUNC_DIV: sel = div_res;
      default:           sel = '{zero: 1'b1, exp: '0, frac: '0, err: 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    res_zero  <= sel.zero;
    res_exp   <= sel.exp;
    res_frac  <= sel.frac;
    div_error <= sel.err;
  end

  // every result strobe goes back to an accepted word
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT + 1))
    else $error("result strobe without an accepted word");

  // a zero result carries a clean exponent and fraction
  a_zero_clean: assert property (@(posedge clk) disable iff (rst)
    (done && res_zero) |-> (res_exp == 64'd0 && res_frac == 52'd0))
    else $error("zero result with nonzero payload");

  // division error only on a zero result of a divide
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && div_error) |-> (res_zero && $past(func, LAT + 1) == eef_pkg::FUNC_DIV))
    else $error("division error outside a divide by zero");

  // multiply of nonzero operands never gives zero
  a_mul_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(func, LAT + 1) == eef_pkg::FUNC_MUL && !$past(a_zero, LAT + 1)
     && !$past(b_zero, LAT + 1)) |-> !res_zero)
    else $error("multiply of nonzero operands gave zero");

endmodule
`default_nettype wire

/* rtl/eef_add.sv */
// three stage adder: operand select, align and add, renormalize and round
`default_nettype none
module eef_add (
  input  wire logic         clk,
  input  wire eef_pkg::op_t a,
  input  wire eef_pkg::op_t b,
  output eef_pkg::res_t     res
);

  logic [eef_pkg::SIG_W-1:0] am, bm;
  logic                      a_big, eq;

  logic                      s1_zero, s1_eq;
  logic [eef_pkg::SIG_W-1:0] s1_lm, s1_sm;
  logic [eef_pkg::EXP_W-1:0] s1_diff, s1_e;

  logic                      s2_zero, s2_eq;
  logic [eef_pkg::SIG_W:0]   s2_s;
  logic [eef_pkg::EXP_W-1:0] s2_e;

  logic [eef_pkg::SIG_W-1:0] shifted;
  logic [eef_pkg::SIG_W:0]   t;
  logic                      up;

  assign am    = {1'b1, a.frac};
  assign bm    = {1'b1, b.frac};
  assign a_big = $signed(a.exp) > $signed(b.exp);
  assign eq    = a.exp == b.exp;

  // stage 1: pick larger operand, exponent difference
  always_ff @(posedge clk) begin
    s1_zero <= a.zero && b.zero;
    if (a.zero || b.zero) begin
      // one operand zero: pass the other through unchanged
      s1_eq   <= 1'b0;
      s1_lm   <= a.zero ? bm : am;
      s1_sm   <= '0;
      s1_diff <= '0;
      s1_e    <= a.zero ? b.exp : a.exp;
    end else begin
      s1_eq   <= eq;
      s1_lm   <= a_big ? am : bm;
      s1_sm   <= a_big ? bm : am;
      s1_diff <= a_big ? a.exp - b.exp : b.exp - a.exp;
      s1_e    <= a_big ? a.exp : b.exp;
    end
  end

  // stage 2: align and add; large shift drops the smaller operand
  assign shifted = (s1_eq || s1_diff[eef_pkg::EXP_W-1:6] == '0)
                   ? (s1_sm >> s1_diff[5:0]) : '0;

  always_ff @(posedge clk) begin
    s2_zero <= s1_zero;
    s2_eq   <= s1_eq;
    s2_s    <= {1'b0, s1_lm} + {1'b0, shifted};
    s2_e    <= s1_e;
  end

  // stage 3: equal exponents round to nearest even, else truncate on carry
  assign up = s2_s[0] && s2_s[1];
  assign t  = {1'b0, s2_s[eef_pkg::SIG_W:1]} + {{eef_pkg::SIG_W{1'b0}}, up};

  always_ff @(posedge clk) begin
    res.zero <= s2_zero;
    res.err  <= 1'b0;
    if (s2_zero) begin
      res.exp  <= '0;
      res.frac <= '0;
    end else if (s2_eq) begin
      res.frac <= t[eef_pkg::SIG_W] ? t[eef_pkg::FRAC_W:1] : t[eef_pkg::FRAC_W-1:0];
      res.exp  <= s2_e + 64'd1 + {63'd0, t[eef_pkg::SIG_W]};
    end else begin
      res.frac <= s2_s[eef_pkg::SIG_W] ? s2_s[eef_pkg::FRAC_W:1]
                                       : s2_s[eef_pkg::FRAC_W-1:0];
      res.exp  <= s2_e + {63'd0, s2_s[eef_pkg::SIG_W]};
    end
  end

endmodule
`default_nettype wire

/* rtl/eef_mul.sv */
// five stage multiplier from partial products of 32 and 21 bit halves, round to nearest even
`default_nettype none
module eef_mul (
  input  wire logic         clk,
  input  wire eef_pkg::op_t a,
  input  wire eef_pkg::op_t b,
  output eef_pkg::res_t     res
);

  logic [52:0] am, bm;

  logic [63:0]  s1_ll;
  logic [52:0]  s1_lh, s1_hl;
  logic [41:0]  s1_hh;
  logic [63:0]  s1_e;
  logic         s1_zero;

  logic [63:0]  s2_ll;
  logic [53:0]  s2_mid;
  logic [41:0]  s2_hh;
  logic [63:0]  s2_e;
  logic         s2_zero;

  logic [105:0] s3_p;
  logic [63:0]  s3_e;
  logic         s3_zero;

  logic [52:0]  s4_q;
  logic         s4_up;
  logic [63:0]  s4_e;
  logic         s4_zero;

  logic         top;
  logic [52:0]  q;
  logic         up;
  logic [53:0]  t;

  assign am = {1'b1, a.frac};
  assign bm = {1'b1, b.frac};

  always_ff @(posedge clk) begin
    s1_ll   <= am[31:0] * bm[31:0];
    s1_lh   <= am[31:0] * bm[52:32];
    s1_hl   <= am[52:32] * bm[31:0];
    s1_hh   <= am[52:32] * bm[52:32];
    s1_e    <= a.exp + b.exp;
    s1_zero <= a.zero || b.zero;
  end

  always_ff @(posedge clk) begin
    s2_ll   <= s1_ll;
    s2_mid  <= {1'b0, s1_lh} + {1'b0, s1_hl};
    s2_hh   <= s1_hh;
    s2_e    <= s1_e;
    s2_zero <= s1_zero;
  end

  always_ff @(posedge clk) begin
    s3_p    <= {s2_hh, 64'd0} + {20'd0, s2_mid, 32'd0} + {42'd0, s2_ll};
    s3_e    <= s2_e;
    s3_zero <= s2_zero;
  end

  // product lies in [2^104, 2^106): keep 53 bits from the leading one down
  assign top = s3_p[105];
  assign q   = top ? s3_p[105:53] : s3_p[104:52];
  assign up  = top ? (s3_p[52] && ((|s3_p[51:0]) || q[0]))
                   : (s3_p[51] && ((|s3_p[50:0]) || q[0]));

  always_ff @(posedge clk) begin
    s4_q    <= q;
    s4_up   <= up;
    s4_e    <= s3_e + {63'd0, top};
    s4_zero <= s3_zero;
  end

  assign t = {1'b0, s4_q} + {53'd0, s4_up};

  always_ff @(posedge clk) begin
    res.zero <= s4_zero;
    res.err  <= 1'b0;
    if (s4_zero) begin
      res.exp  <= '0;
      res.frac <= '0;
    end else begin
      res.frac <= t[53] ? t[52:1] : t[51:0];
      res.exp  <= s4_e + {63'd0, t[53]};
    end
  end

endmodule
`default_nettype wire

/* rtl/eef_div.sv */
// pipelined restoring divider, two quotient bits per stage, round to nearest even
`default_nettype none
module eef_div (
  input  wire logic         clk,
  input  wire eef_pkg::op_t a,
  input  wire eef_pkg::op_t b,
  output eef_pkg::res_t     res
);

  localparam int N = eef_pkg::DIV_ITER_STAGES;

  function automatic logic [105:0] div_step(input logic [52:0] r, input logic [52:0] q,
                                            input logic [52:0] d);
    logic [53:0] r2;
    logic [52:0] rn;
    logic        bit_q;
    r2    = {r, 1'b0};
    bit_q = r2 >= {1'b0, d};
    rn    = bit_q ? 53'(r2 - {1'b0, d}) : r2[52:0];
    return {rn, q[51:0], bit_q};
  endfunction

  logic [52:0] am, bm;
  logic        lt;
  logic [53:0] x;

  logic [52:0] st_r [0:N];
  logic [52:0] st_q [0:N];
  logic [52:0] st_d [0:N];
  logic [63:0] st_e [0:N];
  logic        st_zero [0:N];
  logic        st_err  [0:N];

  logic [53:0] r2f;
  logic [52:0] f_q;
  logic        f_up;
  logic [63:0] f_e;
  logic        f_zero, f_err;
  logic [53:0] t;

  assign am = {1'b1, a.frac};
  assign bm = {1'b1, b.frac};
  assign lt = am < bm;
  // scale the dividend so the quotient lies in [1, 2)
  assign x  = lt ? {am, 1'b0} : {1'b0, am};

  always_ff @(posedge clk) begin
    st_r[0]    <= 53'(x - {1'b0, bm});
    st_q[0]    <= 53'd1;
    st_d[0]    <= bm;
    st_e[0]    <= a.exp - b.exp - {63'd0, lt};
    st_zero[0] <= a.zero || b.zero;
    st_err[0]  <= b.zero;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      logic [105:0] v;
      v = {st_r[k], st_q[k]};
      for (int j = 0; j < eef_pkg::DIV_STEPS; j++) begin
        v = div_step(v[105:53], v[52:0], st_d[k]);
      end
      st_r[k+1]    <= v[105:53];
      st_q[k+1]    <= v[52:0];
      st_d[k+1]    <= st_d[k];
      st_e[k+1]    <= st_e[k];
      st_zero[k+1] <= st_zero[k];
      st_err[k+1]  <= st_err[k];
    end
  end

  // compare twice the remainder with the divisor
  assign r2f = {st_r[N], 1'b0};

  always_ff @(posedge clk) begin
    f_q    <= st_q[N];
    f_up   <= (r2f > {1'b0, st_d[N]}) || ((r2f == {1'b0, st_d[N]}) && st_q[N][0]);
    f_e    <= st_e[N];
    f_zero <= st_zero[N];
    f_err  <= st_err[N];
  end

  assign t = {1'b0, f_q} + {53'd0, f_up};

  always_ff @(posedge clk) begin
    res.zero <= f_zero;
    res.err  <= f_err;
    if (f_zero) begin
      res.exp  <= '0;
      res.frac <= '0;
    end else begin
      res.frac <= t[53] ? t[52:1] : t[51:0];
      res.exp  <= f_e + {63'd0, t[53]};
    end
  end

endmodule
`default_nettype wire

/* bench/tb.sv */
// self-checking bench for the extended exponent float alu: directed corners, then random words
`default_nettype none
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = eef_pkg::FUNC_ADD;
  logic        a_zero = 1'b0;
  logic [63:0] a_exp = '0;
  logic [51:0] a_frac = '0;
  logic        b_zero = 1'b0;
  logic [63:0] b_exp = '0;
  logic [51:0] b_frac = '0;
  logic        done;
  logic        res_zero;
  logic [63:0] res_exp;
  logic [51:0] res_frac;
  logic        div_error;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [63:0] EXP_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] EXP_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [51:0] FRAC_ONES = {52{1'b1}};
  localparam int LIMIT_CYCLES = 400000;

  // result words still on their way out of the pipeline, oldest first
  eef_pkg::res_t pending_results[$];
  int   fail_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;

  extended_exponent_float_alu dut (
    .clk, .rst, .start, .busy, .func, .a_zero, .a_exp, .a_frac,
    .b_zero, .b_exp, .b_frac, .done, .res_zero, .res_exp, .res_frac, .div_error
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // round a kept significand up when asked; a carry out renormalizes by one place
  function automatic logic [53:0] round_sig(logic [53:0] q, logic up, ref logic [63:0] e);
    if (up) q = q + 1;
    if (q[53]) begin
      q = q >> 1;
      e = e + 1;
    end
    return q;
  endfunction

  // expected result word of one operation
  function automatic eef_pkg::res_t alu_result(logic [1:0] f, eef_pkg::op_t a,
                                               eef_pkg::op_t b);
    eef_pkg::res_t r;
    logic [53:0] am, bm, q, s, lm, sm;
    logic [63:0] e, diff;
    logic [105:0] prod;
    logic [53:0] rem, half;
    logic [54:0] rr;
    logic a_big;
    int sh;
    r = '0;
    am = {2'b01, a.frac};
    bm = {2'b01, b.frac};
    case (f)
      eef_pkg::FUNC_ADD: begin
        if (a.zero && b.zero) begin
          r.zero = 1'b1;
        end else if (a.zero || b.zero) begin
          r.exp  = a.zero ? b.exp : a.exp;
          r.frac = a.zero ? b.frac : a.frac;
        end else if (a.exp == b.exp) begin
          // equal exponents: sum always carries, so halve and round to even
          s = am + bm;
          q = s >> 1;
          e = a.exp + 1;
          q = round_sig(q, s[0] && q[0], e);
          r.exp = e;
          r.frac = q[51:0];
        end else begin
          // unequal exponents: align smaller, truncate, renormalize on carry
          a_big = $signed(a.exp) > $signed(b.exp);
          lm = a_big ? am : bm;
          sm = a_big ? bm : am;
          diff = a_big ? a.exp - b.exp : b.exp - a.exp;
          e = a_big ? a.exp : b.exp;
          s = lm + ((diff >= 64) ? 54'd0 : (sm >> diff));
          if (s[53]) begin
            s = s >> 1;
            e = e + 1;
          end
          r.exp = e;
          r.frac = s[51:0];
        end
      end
      eef_pkg::FUNC_MUL: begin
        if (a.zero || b.zero) begin
          r.zero = 1'b1;
        end else begin
          prod = am[52:0] * bm[52:0];
          e = a.exp + b.exp;
          sh = 52;
          if (prod[105]) begin
            sh = 53;
            e = e + 1;
          end
          q = 54'(prod >> sh);
          rem = 54'(prod & ((106'd1 << sh) - 1));
          half = 54'd1 << (sh - 1);
          q = round_sig(q, rem > half || (rem == half && q[0]), e);
          r.exp = e;
          r.frac = q[51:0];
        end
      end
      eef_pkg::FUNC_DIV: begin
        if (b.zero) begin
          r.zero = 1'b1;
          r.err = 1'b1;
        end else if (a.zero) begin
          r.zero = 1'b1;
        end else begin
          // restoring long division to 53 quotient bits plus a round compare
          e = a.exp - b.exp;
          sh = 52;
          if (am < bm) begin
            sh = 53;
            e = e - 1;
          end
          q = am / bm;
          rr = {1'b0, am % bm};
          for (int i = 0; i < sh; i++) begin
            rr = rr << 1;
            q = q << 1;
            if (rr >= bm) begin
              rr = rr - bm;
              q[0] = 1'b1;
            end
          end
          rr = rr << 1;
          q = round_sig(q, rr > bm || (rr == bm && q[0]), e);
          r.exp = e;
          r.frac = q[51:0];
        end
      end
      default: r.zero = 1'b1;
    endcase
    return r;
  endfunction

  // send one word, waiting out random idle cycles first
  task automatic send_word(logic [1:0] f, eef_pkg::op_t a, eef_pkg::op_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    func   <= f;
    a_zero <= a.zero;
    a_exp  <= a.exp;
    a_frac <= a.frac;
    b_zero <= b.zero;
    b_exp  <= b.exp;
    b_frac <= b.frac;
    do @(posedge clk); while (busy);
    pending_results.push_back(alu_result(f, a, b));
  endtask

  function automatic eef_pkg::op_t mk_op(logic z, logic [63:0] e, logic [51:0] f);
    eef_pkg::op_t o;
    o.zero = z;
    o.exp = e;
    o.frac = f;
    return o;
  endfunction

  // random exponent: mostly near each other so adds overlap, sometimes anywhere
  function automatic logic [63:0] rand_exp(logic [63:0] near);
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return near + 64'($signed($urandom_range(140)) - 70);
      2: return near + 64'($signed($urandom_range(6)) - 3);
      default: return near;
    endcase
  endfunction

  function automatic eef_pkg::op_t rand_op(logic [63:0] near);
    logic [51:0] f;
    f = 52'({$urandom, $urandom});
    case ($urandom_range(9))
      0: f = '0;
      1: f = FRAC_ONES;
      default: ;
    endcase
    return mk_op($urandom_range(15) == 0, rand_exp(near), f);
  endfunction

  task automatic test_directed();
    eef_pkg::op_t one, big, tiny, z, mx;
    one  = mk_op(1'b0, 64'd0, '0);
    mx   = mk_op(1'b0, 64'd0, FRAC_ONES);
    big  = mk_op(1'b0, EXP_MAX, FRAC_ONES);
    tiny = mk_op(1'b0, EXP_MIN, '0);
    z    = mk_op(1'b1, EXP_MAX, FRAC_ONES);
    send_word(eef_pkg::FUNC_ADD, z, z);              // both zero
    send_word(eef_pkg::FUNC_ADD, z, mx);             // zero operand passes the other
    send_word(eef_pkg::FUNC_ADD, big, z);
    send_word(eef_pkg::FUNC_ADD, one, mx);           // equal exponents, rounding
    send_word(eef_pkg::FUNC_ADD, mx, mx);
    send_word(eef_pkg::FUNC_ADD, big, big);          // exponent wraps
    send_word(eef_pkg::FUNC_ADD, mk_op(1'b0, 64'd63, FRAC_ONES), mx); // shift just under 64
    send_word(eef_pkg::FUNC_ADD, mk_op(1'b0, 64'd64, '0), mx);        // shift of 64 drops b
    send_word(eef_pkg::FUNC_ADD, big, tiny);         // largest difference
    send_word(eef_pkg::FUNC_ADD, mk_op(1'b0, 64'd1, FRAC_ONES), mx);  // carry renormalize
    send_word(eef_pkg::FUNC_MUL, one, one);
    send_word(eef_pkg::FUNC_MUL, mx, mx);            // product carry
    send_word(eef_pkg::FUNC_MUL, big, big);          // exponent wraps
    send_word(eef_pkg::FUNC_MUL, tiny, tiny);
    send_word(eef_pkg::FUNC_MUL, z, one);
    send_word(eef_pkg::FUNC_MUL, one, z);
    send_word(eef_pkg::FUNC_DIV, one, z);            // divide by zero
    send_word(eef_pkg::FUNC_DIV, z, z);              // zero by zero still errors
    send_word(eef_pkg::FUNC_DIV, z, one);
    send_word(eef_pkg::FUNC_DIV, one, mx);           // a below b
    send_word(eef_pkg::FUNC_DIV, mx, one);
    send_word(eef_pkg::FUNC_DIV, tiny, big);         // exponent wraps
    send_word(eef_pkg::FUNC_DIV, mk_op(1'b0, 64'd5, 52'h5555555555555),
              mk_op(1'b0, 64'd2, 52'h1));
    send_word(FUNC_NONE, mx, big);                   // unused selector
  endtask

  task automatic test_random(int n);
    eef_pkg::op_t a, b;
    logic [1:0] f;
    for (int i = 0; i < n; i++) begin
      a = rand_op({$urandom, $urandom});
      b = rand_op(a.exp);
      f = ($urandom_range(39) == 0) ? FUNC_NONE : 2'($urandom_range(2));
      send_word(f, a, b);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 0;
    test_random(400);
    send_idle_pct = 86;
    test_random(400);
    send_idle_pct = 30;
    test_random(450);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // let any stray word show up before closing
    repeat (eef_pkg::DIV_LAT + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("extended_exponent_float_alu verification clean");
    end else begin
      $display("extended_exponent_float_alu verification failed");
    end
    $finish;
  end

  // result checker: every done word is compared with the oldest prediction
  always @(posedge clk) begin
    eef_pkg::res_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_zero !== want.zero) begin
          $error("res_zero expected %0d got %0d", want.zero, res_zero);
          fail_count++;
        end
        if (res_exp !== want.exp) begin
          $error("res_exp expected %h got %h", want.exp, res_exp);
          fail_count++;
        end
        if (res_frac !== want.frac) begin
          $error("res_frac expected %h got %h", want.frac, res_frac);
          fail_count++;
        end
        if (div_error !== want.err) begin
          $error("div_error expected %0d got %0d", want.err, div_error);
          fail_count++;
        end
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("extended_exponent_float_alu verification failed");
      $finish;
    end
  end
endmodule
`default_nettype wire

/* filelist.f */
rtl/eef_pkg.sv
rtl/eef_add.sv
rtl/eef_mul.sv
rtl/eef_div.sv
rtl/extended_exponent_float_alu.sv
bench/tb.sv
